### hdl/psw_pkg.sv
// shared types and constants for the priority schedule wait time block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package psw_pkg;
   localparam int ID_W    = 8;
   localparam int BURST_W = 16;
   localparam int PRIO_W  = 8;
   localparam int TIME_W  = 20;
   localparam int AVG_W   = 28;
   localparam int FRAC_W  = 8;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   typedef struct packed {
      logic [PRIO_W-1:0]  prio;
      logic [BURST_W-1:0] burst;
      logic [ID_W-1:0]    id;
   } job_type;
endpackage
`default_nettype wire

### hdl/psw_store.sv
// job memory: one write port, one read port with registered read data
// depends on psw_pkg
`timescale 1ns / 1ps
`default_nettype none
module psw_store
   import psw_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic    clock,
   input  wire logic    wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire job_type wr_data,
   input  wire logic    rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output job_type      rd_data
);
   job_type mem [DEPTH];
   job_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;
endmodule
`default_nettype wire

### hdl/psw_div.sv
// restoring divider, one quotient bit per cycle
// depends on nothing else
`timescale 1ns / 1ps
`default_nettype none
module psw_div #(
   parameter int DW = 33,
   parameter int NW = 5
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [NW-1:0] divisor,
   output logic               done,
   output logic [DW-1:0]      quotient
);
   localparam int SCW = $clog2(DW + 1);

   logic [DW-1:0]  q_ff, q_in;
   logic [NW-1:0]  rem_ff, rem_in;
   logic [SCW-1:0] step_ff, step_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [NW:0]    trial;

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, q_ff[DW-1]};
      if (start) begin
         q_in    = dividend;
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = NW'(trial - {1'b0, divisor});
            q_in   = {q_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[NW-1:0];
            q_in   = {q_ff[DW-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == SCW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;
endmodule
`default_nettype wire

### hdl/priority_schedule_wait_times.sv
// Non-preemptive priority scheduler. Jobs load at one per cycle into a job memory until an
// item with last_job set arrives; jobs past MAX_PROCS are dropped and flagged. With n jobs
// held, the block then makes n selection sweeps over the memory (one read a cycle) to find
// jobs in ascending priority, ties in load order, and sum wait and turnaround times; a
// bit-serial divide forms the averages; then n more sweeps, each followed by one result
// that waits for rsp_ready.
// No new item is taken until the last result of a set is accepted.
// depends on psw_pkg, psw_store, psw_div
`timescale 1ns / 1ps
`default_nettype none
module priority_schedule_wait_times
   import psw_pkg::*;
#(
   parameter int MAX_PROCS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [ID_W-1:0]    req_job_id,
   input  wire logic [BURST_W-1:0] req_burst_time,
   input  wire logic [PRIO_W-1:0]  req_job_priority,
   input  wire logic               req_last_job,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [ID_W-1:0]         rsp_out_job_id,
   output logic [BURST_W-1:0]      rsp_out_burst,
   output logic [PRIO_W-1:0]       rsp_out_priority,
   output logic [TIME_W-1:0]       rsp_wait_time,
   output logic [TIME_W-1:0]       rsp_turnaround,
   output logic [AVG_W-1:0]        rsp_avg_wait,
   output logic [AVG_W-1:0]        rsp_avg_turnaround,
   output logic                    rsp_dropped_flag,
   output logic                    rsp_last_result
);
   localparam int AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CW = $clog2(MAX_PROCS + 1);
   localparam int SW = TIME_W + CW;
   localparam int DW = SW + FRAC_W;
   localparam int KW = PRIO_W + AW;

   localparam logic [1:0] S_LOAD = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0]    st_ff, st_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          ovf_ff, ovf_in;
   logic          emit_ff, emit_in;
   logic [CW-1:0] pass_ff, pass_in;
   logic [CW-1:0] sc_ff, sc_in;
   logic          rv_ff, rv_in;
   logic [AW-1:0] ridx_ff, ridx_in;
   logic          have_prev_ff, have_prev_in;
   logic [KW-1:0] prev_ff, prev_in;
   logic          found_ff, found_in;
   logic [KW-1:0] best_ff, best_in;
   job_type       bjob_ff, bjob_in;
   logic [TIME_W-1:0] run_ff, run_in;
   logic [SW-1:0] sumw_ff, sumw_in, sumt_ff, sumt_in;
   logic [AVG_W-1:0] aw_ff, aw_in, at_ff, at_in;
   job_type       ojob_ff, ojob_in;
   logic [TIME_W-1:0] owait_ff, owait_in, otat_ff, otat_in;
   logic          olast_ff, olast_in;

   logic          wr_en, rd_en, issue, qual, div_start, div_done, div_done_t;
   logic [KW-1:0] key;
   logic [TIME_W:0] run_sum;
   logic [TIME_W-1:0] run_next;
   job_type       wr_job, rd_job;
   logic [DW-1:0] qw, qt;

   assign wr_job = '{prio: req_job_priority, burst: req_burst_time, id: req_job_id};
   assign issue  = (st_ff == S_SCAN) && (sc_ff < cnt_ff);
   assign rd_en  = issue;
   assign key    = {rd_job.prio, ridx_ff};
   assign qual   = !have_prev_ff || (key > prev_ff);
   assign run_sum  = {1'b0, run_ff} + (TIME_W + 1)'(bjob_ff.burst);
   assign run_next = (run_sum > {1'b0, TIME_MAX}) ? TIME_MAX : run_sum[TIME_W-1:0];
   assign req_ready = (st_ff == S_LOAD);

   psw_store #(.DEPTH(MAX_PROCS), .AW(AW)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data (wr_job),
      .rd_en   (rd_en),
      .rd_addr (sc_ff[AW-1:0]),
      .rd_data (rd_job)
   );

   // dividends take the sums including the last job, loaded at start
   psw_div #(.DW(DW), .NW(CW)) u_div_w (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sumw_in, FRAC_W'(0)}),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (qw)
   );

   psw_div #(.DW(DW), .NW(CW)) u_div_t (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sumt_in, FRAC_W'(0)}),
      .divisor  (cnt_ff),
      .done     (div_done_t),
      .quotient (qt)
   );

   always_comb begin
      st_in        = st_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      emit_in      = emit_ff;
      pass_in      = pass_ff;
      sc_in        = sc_ff;
      rv_in        = 1'b0;
      ridx_in      = sc_ff[AW-1:0];
      have_prev_in = have_prev_ff;
      prev_in      = prev_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      bjob_in      = bjob_ff;
      run_in       = run_ff;
      sumw_in      = sumw_ff;
      sumt_in      = sumt_ff;
      aw_in        = aw_ff;
      at_in        = at_ff;
      ojob_in      = ojob_ff;
      owait_in     = owait_ff;
      otat_in      = otat_ff;
      olast_in     = olast_ff;
      wr_en        = 1'b0;
      div_start    = 1'b0;
      case (st_ff)
         S_LOAD: begin
            if (req_valid) begin
               if (cnt_ff < CW'(MAX_PROCS)) begin
                  wr_en  = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_job) begin
                  st_in        = S_SCAN;
                  emit_in      = 1'b0;
                  pass_in      = '0;
                  sc_in        = '0;
                  found_in     = 1'b0;
                  have_prev_in = 1'b0;
                  run_in       = '0;
                  sumw_in      = '0;
                  sumt_in      = '0;
               end
            end
         end
         S_SCAN: begin
            if (issue) begin
               sc_in = sc_ff + 1'b1;
               rv_in = 1'b1;
            end
            // keep the smallest key above the one picked last sweep
            if (rv_ff && qual && (!found_ff || key < best_ff)) begin
               best_in  = key;
               bjob_in  = rd_job;
               found_in = 1'b1;
            end
            if (!issue && !rv_ff) begin
               run_in       = run_next;
               prev_in      = best_ff;
               have_prev_in = 1'b1;
               pass_in      = pass_ff + 1'b1;
               sc_in        = '0;
               found_in     = 1'b0;
               if (emit_ff) begin
                  ojob_in  = bjob_ff;
                  owait_in = run_ff;
                  otat_in  = run_next;
                  olast_in = (pass_ff + 1'b1 == cnt_ff);
                  st_in    = S_OUT;
               end else begin
                  sumw_in = sumw_ff + SW'(run_ff);
                  sumt_in = sumt_ff + SW'(run_next);
                  if (pass_ff + 1'b1 == cnt_ff) begin
                     div_start = 1'b1;
                     st_in     = S_DIV;
                  end
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               aw_in        = qw[AVG_W-1:0];
               at_in        = qt[AVG_W-1:0];
               st_in        = S_SCAN;
               emit_in      = 1'b1;
               pass_in      = '0;
               sc_in        = '0;
               found_in     = 1'b0;
               have_prev_in = 1'b0;
               run_in       = '0;
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               if (olast_ff) begin
                  cnt_in = '0;
                  ovf_in = 1'b0;
                  st_in  = S_LOAD;
               end else begin
                  st_in = S_SCAN;
               end
            end
         end
         default: begin
            st_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= S_LOAD;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
         rv_ff  <= 1'b0;
      end else begin
         st_ff  <= st_in;
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
         rv_ff  <= rv_in;
      end
      emit_ff      <= emit_in;
      pass_ff      <= pass_in;
      sc_ff        <= sc_in;
      ridx_ff      <= ridx_in;
      have_prev_ff <= have_prev_in;
      prev_ff      <= prev_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      bjob_ff      <= bjob_in;
      run_ff       <= run_in;
      sumw_ff      <= sumw_in;
      sumt_ff      <= sumt_in;
      aw_ff        <= aw_in;
      at_ff        <= at_in;
      ojob_ff      <= ojob_in;
      owait_ff     <= owait_in;
      otat_ff      <= otat_in;
      olast_ff     <= olast_in;
   end

   assign rsp_valid          = (st_ff == S_OUT);
   assign rsp_out_job_id     = ojob_ff.id;
   assign rsp_out_burst      = ojob_ff.burst;
   assign rsp_out_priority   = ojob_ff.prio;
   assign rsp_wait_time      = owait_ff;
   assign rsp_turnaround     = otat_ff;
   assign rsp_avg_wait       = aw_ff;
   assign rsp_avg_turnaround = at_ff;
   assign rsp_dropped_flag   = ovf_ff;
   assign rsp_last_result    = olast_ff;

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while a result is shown");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_PROCS))
      else $error("job count beyond capacity");
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_DIV) |-> (cnt_ff != '0))
      else $error("divide with empty job set");
   a_div_pair: assert property (@(posedge clock) disable iff (reset)
      div_done == div_done_t)
      else $error("dividers out of step");
   a_set_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_result) |=> (req_ready && cnt_ff == '0))
      else $error("set not cleared after final item");
`endif
endmodule
`default_nettype wire

### bench/tb_top.sv
// testbench for priority_schedule_wait_times: loads job sets, predicts the ordered
// schedule with wait, turnaround and averages, and checks every result item
// depends on psw_pkg and the priority_schedule_wait_times rtl
`timescale 1ns / 1ps

class schedule_board;
   localparam int CAP = 16;
   psw_pkg::job_type held[$];
   bit               overflow;
   logic [129:0]     expected_q[$];
   int               errors;

   // store one job; on last, build the schedule and queue its result items
   function void note_job(psw_pkg::job_type j, bit last);
      psw_pkg::job_type order[$];
      longint run, sum_w, sum_t, w, t, aw, at;
      int n, k;
      if (held.size() < CAP) held.push_back(j);
      else overflow = 1;
      if (!last) return;
      n = held.size();
      // stable sort by priority
      for (int i = 0; i < n; i++) begin
         k = order.size();
         while (k > 0 && order[k-1].prio > held[i].prio) k--;
         order.insert(k, held[i]);
      end
      run = 0; sum_w = 0; sum_t = 0;
      for (int i = 0; i < n; i++) begin
         w = (run > 1048575) ? 1048575 : run;
         t = w + order[i].burst;
         if (t > 1048575) t = 1048575;
         run += order[i].burst;
         sum_w += w; sum_t += t;
      end
      aw = (sum_w << 8) / n; at = (sum_t << 8) / n;
      if (aw > 268435455) aw = 268435455;
      if (at > 268435455) at = 268435455;
      run = 0;
      for (int i = 0; i < n; i++) begin
         w = (run > 1048575) ? 1048575 : run;
         t = w + order[i].burst;
         if (t > 1048575) t = 1048575;
         run += order[i].burst;
         expected_q.push_back({order[i].id, order[i].burst, order[i].prio, w[19:0], t[19:0],
                               aw[27:0], at[27:0], overflow, i == n - 1});
      end
      held.delete();
      overflow = 0;
   endfunction

   function void check_result(logic [129:0] got);
      logic [129:0] e;
      if (expected_q.size() == 0) begin
         $error("result with no item expected");
         errors++;
         return;
      end
      e = expected_q.pop_front();
      if (got === e) return;
      errors++;
      if (got[129:122] !== e[129:122])
         $error("out_job_id exp %0d got %0d", e[129:122], got[129:122]);
      if (got[121:106] !== e[121:106])
         $error("out_burst exp %0d got %0d", e[121:106], got[121:106]);
      if (got[105:98] !== e[105:98])
         $error("out_priority exp %0d got %0d", e[105:98], got[105:98]);
      if (got[97:78] !== e[97:78]) $error("wait_time exp %0d got %0d", e[97:78], got[97:78]);
      if (got[77:58] !== e[77:58]) $error("turnaround exp %0d got %0d", e[77:58], got[77:58]);
      if (got[57:30] !== e[57:30]) $error("avg_wait exp %0d got %0d", e[57:30], got[57:30]);
      if (got[29:2] !== e[29:2])
         $error("avg_turnaround exp %0d got %0d", e[29:2], got[29:2]);
      if (got[1] !== e[1]) $error("dropped_flag exp %0d got %0d", e[1], got[1]);
      if (got[0] !== e[0]) $error("last_result exp %0d got %0d", e[0], got[0]);
   endfunction
endclass

module tb_top;
   import psw_pkg::*;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready, req_last_job = 0;
   logic [ID_W-1:0] req_job_id = 0;
   logic [BURST_W-1:0] req_burst_time = 0;
   logic [PRIO_W-1:0] req_job_priority = 0;
   logic rsp_valid, rsp_ready = 0;
   logic [ID_W-1:0] rsp_out_job_id;
   logic [BURST_W-1:0] rsp_out_burst;
   logic [PRIO_W-1:0] rsp_out_priority;
   logic [TIME_W-1:0] rsp_wait_time, rsp_turnaround;
   logic [AVG_W-1:0] rsp_avg_wait, rsp_avg_turnaround;
   logic rsp_dropped_flag, rsp_last_result;

   schedule_board board = new;
   bit quiet_phase = 0;
   bit hold_rsp = 0;
   bit stim_done = 0;

   always #4 clock = ~clock;

   priority_schedule_wait_times dut (.*);

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result({rsp_out_job_id, rsp_out_burst, rsp_out_priority, rsp_wait_time,
                             rsp_turnaround, rsp_avg_wait, rsp_avg_turnaround,
                             rsp_dropped_flag, rsp_last_result});
   end

   // receiver with random stall bursts and an optional long hold-off
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 0;
            repeat (300) @(negedge clock);
            hold_rsp = 0;
         end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end else begin
            rsp_ready <= 1;
            @(negedge clock);
         end
      end
   end

   task automatic send_job(input logic [7:0] id, input logic [15:0] burst,
                           input logic [7:0] prio, input bit last);
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid <= 1;
      req_job_id <= id;
      req_burst_time <= burst;
      req_job_priority <= prio;
      req_last_job <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_job('{prio: prio, burst: burst, id: id}, last);
      @(negedge clock);
   endtask

   task automatic send_set(input int n, input int mode);
      logic [15:0] b;
      for (int i = 0; i < n; i++) begin
         case (mode)
            1: b = 16'hFFFF;
            2: b = 16'($urandom_range(0, 3));
            default: b = 16'($urandom);
         endcase
         send_job(8'($urandom), b,
                  (mode == 2) ? 8'($urandom_range(0, 2)) : 8'($urandom), i == n - 1);
      end
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // directed: single job, extremes, ties, overflow
      send_job(8'h00, 16'h0000, 8'h00, 1);
      send_job(8'hFF, 16'hFFFF, 8'hFF, 1);
      send_job(8'h01, 16'h0005, 8'h07, 0);
      send_job(8'h02, 16'h0003, 8'h07, 0);
      send_job(8'h03, 16'h0001, 8'h00, 1);
      send_set(18, 1);
      // random sets, mostly small; one long receiver hold-off
      for (int s = 0; s < 14; s++) begin
         if (s == 3) hold_rsp = 1;
         if (s == 10) quiet_phase = 1;
         send_set((s % 5 == 4) ? $urandom_range(14, 18) : $urandom_range(1, 6), s % 3);
      end
      req_valid <= 0;
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (board.errors == 0 && board.expected_q.size() == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end
endmodule
